>>> rtl/core/allocation_leak_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef ALLOCATION_LEAK_TRACKER_MACROS_SVH
`define ALLOCATION_LEAK_TRACKER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ALT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/alt_pkg.sv
// Shared types and constants for the allocation leak tracker.
`timescale 1ns / 1ps
package alt_pkg;
  localparam int SLOTS     = 64;
  localparam int ADDR_BITS = 48;
  localparam int IDX_BITS  = $clog2(SLOTS);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int SIZE_BITS = 32;
  localparam int LIVE_BITS = 2;
  // slot word: base, size, liveness, warning (base in the top bits)
  localparam int SLOT_BITS = ADDR_BITS + SIZE_BITS + LIVE_BITS + 1;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0, OP_FREE = 3'd1, OP_USE = 3'd2,
    OP_WARN = 3'd3, OP_PEND = 3'd4, OP_CHECK = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0, ST_DUP = 2'd1, ST_MISS = 2'd2, ST_FULL = 2'd3;
  localparam logic [1:0] VD_NONE = 2'd0, VD_LEAK = 2'd1, VD_NOLEAK = 2'd2, VD_BLOAT = 2'd3;
  localparam logic [1:0] LV_INIT = 2'd0, LV_STATIC = 2'd1, LV_LIVE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WB, S_SWEEP, S_OUT
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_BITS-1:0] size;
    logic [LIVE_BITS-1:0] live;
    logic                 warn;
  } slot_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

>>> rtl/core/alt_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module alt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/allocation_leak_tracker.sv
// Top level of the allocation leak tracker: sequencer, slot memory and counters.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: operation, address, alloc_size
//  out_    | out | out_tvalid/out_tready| tdata: status..live_freed
//
// Every request scans all SLOTS entries of the slot memory, one read per
// cycle, then decides and writes back before the result is offered. A pend
// request sweeps every entry after deciding instead, reading each one and
// writing back each valid, warned entry marked static. Valid bits are
// flip-flops cleared at reset and at once by check. A result waits in the
// output register; the next request can be taken in the cycle after it is
// delivered.
`timescale 1ns / 1ps
`include "allocation_leak_tracker_macros.svh"
module allocation_leak_tracker
  import alt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // operation[2:0], address[50:3], alloc_size[82:51]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // status, range_hit, verdict, leak_count,
                                   // static_freed, live_freed
);
  state_t state_r, state_nxt;
  logic [2:0]           op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [SLOTS-1:0]     valid_r;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;   // issue counter
  logic [CNT_BITS-1:0]  rd_r;             // index of data now on rdata
  logic                 rdv_r;
  // scan results
  logic                 ex_hit_r;
  logic [IDX_BITS-1:0]  ex_idx_r;
  slot_t                ex_slot_r;
  logic                 fr_hit_r;
  logic [IDX_BITS-1:0]  fr_idx_r;
  logic                 bb_hit_r;
  logic [IDX_BITS-1:0]  bb_idx_r;
  slot_t                bb_slot_r;
  logic [CNT_BITS-1:0]  warn_n_r;
  logic                 pend_r;
  logic [31:0]          leak_r, sfree_r, lfree_r;
  logic [1:0]           st_r;
  logic                 hit_r;
  logic [1:0]           vd_r;

  logic                 we;
  logic [IDX_BITS-1:0]  ram_addr;
  slot_t                wslot, rslot;

  alt_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wslot), .rdata(rslot)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, lfree_r, sfree_r, leak_r, vd_r, hit_r, st_r};

  logic [IDX_BITS-1:0] rd_idx;
  logic                rd_valid;
  assign rd_idx   = rd_r[IDX_BITS-1:0];
  assign rd_valid = valid_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state, memory port.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    we        = 1'b0;
    ram_addr  = cnt_r[IDX_BITS-1:0];
    wslot     = rslot;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_r < CNT_BITS'(SLOTS)) cnt_nxt = cnt_r + 1'b1;
        if (rdv_r && rd_r == CNT_BITS'(SLOTS - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_nxt = '0;
        if (op_r == OP_PEND) state_nxt = S_SWEEP;
        else                 state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_OUT;
        case (op_r)
          OP_ALLOC: begin
            ram_addr = fr_idx_r;
            we = !ex_hit_r && fr_hit_r;
            wslot = '{base: addr_r, size: size_r, live: LV_INIT, warn: 1'b0};
          end
          OP_USE: begin
            ram_addr = bb_idx_r;
            we = hit_r;
            wslot = bb_slot_r;
            wslot.live = LV_LIVE;
          end
          OP_WARN: begin
            ram_addr = ex_idx_r;
            we = ex_hit_r;
            wslot = ex_slot_r;
            wslot.warn = 1'b1;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        // read at cnt, write back previous entry at rd
        if (rdv_r) begin
          ram_addr = rd_idx;
          we = rd_valid && rslot.warn;
          wslot.live = LV_STATIC;
        end
        if (cnt_r < CNT_BITS'(SLOTS) && !rdv_r) cnt_nxt = cnt_r + 1'b1;
        if (rdv_r && rd_r == CNT_BITS'(SLOTS - 1)) state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [ADDR_BITS:0] diff;
  assign diff = {1'b0, addr_r} - {1'b0, bb_slot_r.base};

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      rdv_r <= 1'b0; valid_r <= '0; pend_r <= 1'b0;
      leak_r <= '0; sfree_r <= '0; lfree_r <= '0;
    end else begin
      rdv_r <= ((state_r == S_SCAN) && cnt_r < CNT_BITS'(SLOTS))
            || ((state_r == S_SWEEP) && !rdv_r && cnt_r < CNT_BITS'(SLOTS));
      rd_r  <= {1'b0, ram_addr};
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[2:0];
          addr_r <= in_tdata[50:3];
          size_r <= in_tdata[82:51];
          ex_hit_r <= 1'b0; fr_hit_r <= 1'b0; bb_hit_r <= 1'b0;
          warn_n_r <= '0; hit_r <= 1'b0; vd_r <= VD_NONE; st_r <= ST_OK;
        end
        S_SCAN: if (rdv_r) begin
          if (rd_valid && rslot.base == addr_r) begin
            ex_hit_r <= 1'b1; ex_idx_r <= rd_idx; ex_slot_r <= rslot;
          end
          if (!rd_valid && !fr_hit_r) begin
            fr_hit_r <= 1'b1; fr_idx_r <= rd_idx;
          end
          if (rd_valid && rslot.base <= addr_r && (!bb_hit_r || rslot.base > bb_slot_r.base)) begin
            bb_hit_r <= 1'b1; bb_idx_r <= rd_idx; bb_slot_r <= rslot;
          end
          if (rd_valid && rslot.warn) warn_n_r <= warn_n_r + 1'b1;
        end
        S_DECIDE: begin
          case (op_r)
            OP_ALLOC: begin
              if (ex_hit_r) st_r <= ST_DUP;
              else if (!fr_hit_r) st_r <= ST_FULL;
            end
            OP_FREE: if (!ex_hit_r) st_r <= ST_MISS;
              else begin
                valid_r[ex_idx_r] <= 1'b0;
                if (ex_slot_r.warn && ex_slot_r.live == LV_STATIC) sfree_r <= sat_inc(sfree_r, 32'd1);
                if (ex_slot_r.warn && ex_slot_r.live == LV_LIVE) lfree_r <= sat_inc(lfree_r, 32'd1);
              end
            OP_USE: hit_r <= bb_hit_r && (diff < {17'd0, bb_slot_r.size});
            OP_WARN: if (!ex_hit_r) st_r <= ST_MISS;
            OP_PEND: pend_r <= 1'b1;
            OP_CHECK: begin
              valid_r <= '0;
              if (pend_r) leak_r <= sat_inc(leak_r, 32'(warn_n_r));
            end
            default: ;
          endcase
        end
        S_WB: begin
          if (op_r == OP_ALLOC && !ex_hit_r && fr_hit_r) valid_r[fr_idx_r] <= 1'b1;
          if (op_r == OP_CHECK && pend_r)
            vd_r <= (leak_r != 0) ? VD_LEAK : (sfree_r == 0) ? VD_NOLEAK : VD_BLOAT;
        end
        default: ;
      endcase
    end
  end

  `ALT_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, !out_tvalid, "ready while result pending")
  `ALT_ASSERT_IMP(a_vd_check, clk, rst_n, out_tvalid && vd_r != VD_NONE, op_r == OP_CHECK, "verdict on non-check")
  `ALT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
endmodule
